### rtl/okd_pkg.sv
// okd_pkg: shared types, constants and the expected-header function
// for the obfuscation key search decoder; no dependencies
package okd_pkg;

   localparam int HDR_LEN = 14;
   localparam int HDR_IDX_W = 4;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   localparam logic [7:0] SIG_B    = 8'h42;
   localparam logic [7:0] SIG_M    = 8'h4D;
   localparam logic [7:0] DATA_OFS = 8'h36;

   typedef struct packed {
      logic       kind;
      logic       first;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic       result_kind;
      logic       found;
      logic [7:0] xor_key;
      logic [7:0] sub_key;
      logic [7:0] plain_byte;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic search_run;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_search;
      logic rsp_busy;
      logic done;
   } status_type;

   // expected decoded header byte at a given position
   function automatic logic [7:0] want_byte(input logic [HDR_IDX_W-1:0] idx,
                                            input logic [31:0] len);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = SIG_B;
         4'd1:    val = SIG_M;
         4'd2:    val = len[7:0];
         4'd3:    val = len[15:8];
         4'd4:    val = len[23:16];
         4'd5:    val = len[31:24];
         4'd10:   val = DATA_OFS;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

### rtl/obfuscation_key_search_decoder_top.sv
// A payload word gives its decoded word in the cycle after acceptance, one
// word per cycle while the result side keeps up and no search runs. Header
// words before the fourteenth give no result. The fourteenth starts the key
// sweep, checking one header byte of one candidate key per cycle and dropping
// a candidate at its first mismatch, then registers the search result.
// Reset (synchronous, active high) clears the header count, keys and length.
module obfuscation_key_search_decoder_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  okd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output okd_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data
);

   okd_pkg::cmd_type    cmd;
   okd_pkg::status_type status;

   // length register always writable
   assign csr_ready = 1'b1;

   okd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   okd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

### rtl/okd_datapath.sv
// okd_datapath: header store, key candidate sweep, payload decode and
// output register; depends on okd_pkg
module okd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  okd_pkg::cmd_type      cmd,
   output okd_pkg::status_type   status,
   input  okd_pkg::req_word_type req_word,
   input  logic                  csr_valid,
   input  logic [31:0]           csr_data,
   output okd_pkg::rsp_word_type rsp_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready
);

   localparam int IdxW = okd_pkg::HDR_IDX_W;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(okd_pkg::HDR_LEN - 1);
   localparam logic [IdxW:0]   HdrLenW = (IdxW + 1)'(okd_pkg::HDR_LEN);

   logic [7:0]      hdr_ff [okd_pkg::HDR_LEN];
   logic [IdxW:0]   hdr_count_ff, hdr_count_in;
   logic [31:0]     entry_len_ff;
   logic [15:0]     cand_ff, cand_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [7:0]      acc_ff, acc_in;
   logic [7:0]      held_x_ff, held_x_in;
   logic [7:0]      held_s_ff, held_s_in;
   logic            key_ready_ff, key_ready_in;
   logic [7:0]      prev_ff, prev_in;
   logic            out_valid_ff, out_valid_in;
   okd_pkg::rsp_word_type out_ff, out_in;

   logic [IdxW:0]   cnt_eff;
   logic            hdr_store_en;
   logic [7:0]      term, acc_sum, pterm, plain;
   logic            byte_ok, last_key, hit, done;

   // header position for this word
   assign cnt_eff      = req_word.first ? '0 : hdr_count_ff;
   assign hdr_store_en = cmd.accept && (req_word.kind == okd_pkg::KIND_HEADER)
                         && (cnt_eff < HdrLenW);

   // one header byte of one candidate checked per cycle
   assign term     = (cand_ff[7:0] ^ hdr_ff[idx_ff]) - cand_ff[15:8];
   assign acc_sum  = (idx_ff == '0) ? term : acc_ff + term;
   assign byte_ok  = (acc_sum == okd_pkg::want_byte(idx_ff, entry_len_ff));
   assign last_key = &cand_ff;
   assign hit      = cmd.search_run && byte_ok && (idx_ff == LastIdx);
   assign done     = hit || (cmd.search_run && !byte_ok && last_key);

   // payload decode with the held key
   assign pterm = (held_x_ff ^ req_word.data_byte) - held_s_ff;
   assign plain = req_word.first ? pterm : prev_ff + pterm;

   always_comb begin
      status.start_search = (req_word.kind == okd_pkg::KIND_HEADER)
                            && (cnt_eff == (IdxW + 1)'(LastIdx));
      status.rsp_busy     = out_valid_ff && !rsp_ready;
      status.done         = done;
   end

   // next-state logic
   always_comb begin
      hdr_count_in = hdr_count_ff;
      cand_in      = cand_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      held_x_in    = held_x_ff;
      held_s_in    = held_s_ff;
      key_ready_in = key_ready_ff;
      prev_in      = prev_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (hdr_store_en) begin
         hdr_count_in = cnt_eff + 1'b1;
         cand_in      = '0;
         idx_in       = '0;
      end

      if (cmd.accept && (req_word.kind == okd_pkg::KIND_PAYLOAD)) begin
         prev_in      = plain;
         out_in       = '{result_kind: okd_pkg::KIND_PAYLOAD, found: key_ready_ff,
                          xor_key: held_x_ff, sub_key: held_s_ff, plain_byte: plain};
         out_valid_in = 1'b1;
      end

      // candidate sweep: x inner, s outer
      if (cmd.search_run) begin
         if (byte_ok) begin
            idx_in = idx_ff + 1'b1;
            acc_in = acc_sum;
         end else begin
            idx_in  = '0;
            cand_in = cand_ff + 16'd1;
         end
      end

      if (done) begin
         held_x_in    = hit ? cand_ff[7:0] : 8'h00;
         held_s_in    = hit ? cand_ff[15:8] : 8'h00;
         key_ready_in = hit;
         out_in       = '{result_kind: okd_pkg::KIND_HEADER, found: hit,
                          xor_key: held_x_in, sub_key: held_s_in, plain_byte: 8'h00};
         out_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff <= '0;
         entry_len_ff <= '0;
         cand_ff      <= '0;
         idx_ff       <= '0;
         held_x_ff    <= '0;
         held_s_ff    <= '0;
         key_ready_ff <= 1'b0;
         prev_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         hdr_count_ff <= hdr_count_in;
         if (csr_valid) begin
            entry_len_ff <= csr_data;
         end
         cand_ff      <= cand_in;
         idx_ff       <= idx_in;
         held_x_ff    <= held_x_in;
         held_s_ff    <= held_s_in;
         key_ready_ff <= key_ready_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (hdr_store_en) begin
         hdr_ff[cnt_eff[IdxW-1:0]] <= req_word.data_byte;
      end
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

   assign rsp_word  = out_ff;
   assign rsp_valid = out_valid_ff;

   // a search result never overwrites an undelivered word
   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      done |-> !out_valid_ff)
      else $error("search finished while output word pending");

   // a hit is only reported on the last header byte
   a_hit_last: assert property (@(posedge clock) disable iff (reset)
      hit |-> (idx_ff == LastIdx))
      else $error("hit before last header byte");

   // starting a search rewinds the sweep
   a_search_init: assert property (@(posedge clock) disable iff (reset)
      (hdr_store_en && status.start_search) |=> (cand_ff == '0 && idx_ff == '0))
      else $error("search did not start at first candidate");

endmodule

### rtl/okd_ctrl.sv
// okd_ctrl: controller state machine for input acceptance and the key sweep
// depends on okd_pkg
module okd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  okd_pkg::status_type status,
   output okd_pkg::cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type state_ff, state_in;

   // take a word when idle and the output slot is free or draining
   assign req_ready = (state_ff == ST_IDLE) && !status.rsp_busy;

   always_comb begin
      cmd.accept     = req_valid && req_ready;
      cmd.search_run = (state_ff == ST_SEARCH);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.start_search) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### tb/sv/tb.sv
// tb: self-checking bench for obfuscation_key_search_decoder_top
// depends on okd_pkg and the top level; predicts every result word itself
`timescale 1ns / 1ps

module tb;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   okd_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   okd_pkg::rsp_word_type rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [31:0]           csr_data = '0;

   // words waiting to be driven and result words still owed by the block
   okd_pkg::req_word_type pending_words[$];
   okd_pkg::rsp_word_type owed_results[$];

   // shadow state of the decoder
   logic [7:0]  hdr_bytes[okd_pkg::HDR_LEN];
   int          hdr_count = 0;
   logic [7:0]  xor_k = '0;
   logic [7:0]  sub_k = '0;
   logic        key_ok = 1'b0;
   logic [7:0]  last_plain = '0;
   logic [31:0] length_cfg = '0;

   int      sender_idle_pct = 0;
   int      receiver_stall_pct = 0;
   bit      hold_request = 1'b0;
   int      error_count = 0;
   longint  cycle_count = 0;
   longint  work_budget = 0;
   int      broken_left = 2;

   obfuscation_key_search_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // plain header byte of a bitmap entry of the given length
   function automatic logic [7:0] bitmap_byte(int pos, logic [31:0] len);
      logic [7:0] val;
      unique case (pos)
         0:       val = okd_pkg::SIG_B;
         1:       val = okd_pkg::SIG_M;
         2:       val = len[7:0];
         3:       val = len[15:8];
         4:       val = len[23:16];
         5:       val = len[31:24];
         10:      val = okd_pkg::DATA_OFS;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // does the stored header decode to a bitmap header under this key pair
   function automatic bit header_fits(logic [7:0] xk, logic [7:0] sk);
      logic [7:0] term;
      logic [7:0] sum;
      sum = '0;
      for (int i = 0; i < okd_pkg::HDR_LEN; i++) begin
         term = (xk ^ hdr_bytes[i]) - sk;
         sum = (i == 0) ? term : sum + term;
         if (sum != bitmap_byte(i, length_cfg))
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // advance the shadow state by one accepted word
   task automatic predict_word(okd_pkg::req_word_type w);
      okd_pkg::rsp_word_type r;
      logic [7:0]   term;
      bit           hit;
      r = '0;
      hit = 1'b0;
      work_budget += 64;
      if (w.kind == okd_pkg::KIND_HEADER) begin
         if (w.first)
            hdr_count = 0;
         if (hdr_count < okd_pkg::HDR_LEN) begin
            hdr_bytes[hdr_count] = w.data_byte;
            hdr_count++;
            // fourteenth byte: sweep sub key outer, xor key inner
            if (hdr_count == okd_pkg::HDR_LEN) begin
               xor_k = '0;
               sub_k = '0;
               for (int s = 0; s < 256 && !hit; s++) begin
                  for (int x = 0; x < 256 && !hit; x++) begin
                     if (header_fits(x[7:0], s[7:0])) begin
                        hit = 1'b1;
                        xor_k = x[7:0];
                        sub_k = s[7:0];
                        work_budget += 14 * (s * 256 + x + 1);
                     end
                  end
               end
               if (!hit)
                  work_budget += 14 * 65536;
               key_ok = hit;
               r.result_kind = okd_pkg::KIND_HEADER;
               r.found = hit;
               r.xor_key = xor_k;
               r.sub_key = sub_k;
               owed_results.push_back(r);
            end
         end
      end else begin
         // running sum decode with the held keys
         term = (xor_k ^ w.data_byte) - sub_k;
         last_plain = w.first ? term : last_plain + term;
         r.result_kind = okd_pkg::KIND_PAYLOAD;
         r.found = key_ok;
         r.xor_key = xor_k;
         r.sub_key = sub_k;
         r.plain_byte = last_plain;
         owed_results.push_back(r);
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // request side driver
   always @(posedge clock) begin : word_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_word(req_word);
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side monitor and ready generation
   always @(posedge clock) begin : result_monitor
      okd_pkg::rsp_word_type want;
      int           hold_left;
      bit           hold_taken;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         hold_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $error("result word %h with nothing owed", rsp_word);
               error_count++;
            end else begin
               want = owed_results.pop_front();
               check_field("result_kind", 32'(want.result_kind),
                           32'(rsp_word.result_kind));
               check_field("found", 32'(want.found), 32'(rsp_word.found));
               check_field("xor_key", 32'(want.xor_key), 32'(rsp_word.xor_key));
               check_field("sub_key", 32'(want.sub_key), 32'(rsp_word.sub_key));
               check_field("plain_byte", 32'(want.plain_byte),
                           32'(rsp_word.plain_byte));
            end
         end
         // one long hold-off on request, otherwise random stalls
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // watchdog scaled by the work accepted so far
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > 4 * work_budget + 100000) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic queue_word(logic kind, logic first, logic [7:0] data);
      okd_pkg::req_word_type w;
      w.kind = kind;
      w.first = first;
      w.data_byte = data;
      pending_words.push_back(w);
   endtask

   // encode a bitmap header with the given keys, optionally breaking one byte
   task automatic queue_entry(logic [7:0] xk, logic [7:0] sk, logic [31:0] len,
                              int broken_pos);
      logic [7:0] prev;
      logic [7:0] term;
      logic [7:0] raw;
      prev = '0;
      for (int i = 0; i < okd_pkg::HDR_LEN; i++) begin
         term = bitmap_byte(i, len) - prev;
         prev = bitmap_byte(i, len);
         raw = (term + sk) ^ xk;
         if (i == broken_pos)
            raw = raw ^ (8'h01 << $urandom_range(7));
         queue_word(okd_pkg::KIND_HEADER, i == 0, raw);
      end
   endtask

   task automatic queue_payload(int n);
      for (int i = 0; i < n; i++)
         queue_word(okd_pkg::KIND_PAYLOAD, i == 0, 8'($urandom_range(255)));
   endtask

   // all words accepted and all results in, then let the block settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || owed_results.size() != 0);
      repeat (32) @(posedge clock);
   endtask

   task automatic write_length(logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      length_cfg = value;
   endtask

   // mostly well-formed entries with random keys and payload, plus noise
   task automatic random_phase(int n_items);
      int made;
      int pick;
      int run;
      made = 0;
      while (made < n_items) begin
         pick = $urandom_range(99);
         if (pick < 70 || (pick >= 95 && broken_left == 0)) begin
            queue_entry(8'($urandom_range(255)), 8'($urandom_range(2)), length_cfg, -1);
            // extra header words past fourteen are dropped by the block
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(2, 1))
                  queue_word(okd_pkg::KIND_HEADER, 1'b0, 8'($urandom_range(255)));
            run = $urandom_range(12, 1);
            queue_payload(run);
            made += okd_pkg::HDR_LEN + run;
         end else if (pick < 85) begin
            run = $urandom_range(6, 1);
            repeat (run)
               queue_word(okd_pkg::KIND_PAYLOAD, 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            made += run;
         end else if (pick < 95) begin
            // header cut short, restarted by the next entry
            run = $urandom_range(13, 1);
            for (int i = 0; i < run; i++)
               queue_word(okd_pkg::KIND_HEADER, i == 0, 8'($urandom_range(255)));
            made += run;
         end else begin
            broken_left--;
            queue_entry(8'($urandom_range(255)), 8'($urandom_range(2)), length_cfg,
                        $urandom_range(okd_pkg::HDR_LEN - 1));
            run = $urandom_range(4, 1);
            queue_payload(run);
            made += okd_pkg::HDR_LEN + run;
         end
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // payload before any key, running sum from reset
      queue_word(okd_pkg::KIND_PAYLOAD, 1'b0, 8'hFF);
      queue_word(okd_pkg::KIND_PAYLOAD, 1'b1, 8'h00);
      wait_idle();

      // matching header at the largest length, then a dropped extra header
      write_length(32'hFFFF_FFFF);
      queue_entry(8'hFF, 8'h00, 32'hFFFF_FFFF, -1);
      queue_word(okd_pkg::KIND_HEADER, 1'b0, 8'h00);
      queue_word(okd_pkg::KIND_PAYLOAD, 1'b1, 8'hFF);
      queue_word(okd_pkg::KIND_PAYLOAD, 1'b0, 8'h00);
      wait_idle();

      // same header against length zero: search fails, keys cleared
      write_length(32'h0000_0000);
      queue_entry(8'hFF, 8'h00, 32'hFFFF_FFFF, -1);
      queue_word(okd_pkg::KIND_PAYLOAD, 1'b0, 8'h5A);

      // sender waits for every result, then the receiver holds off
      wait_idle();
      hold_request = 1'b1;
      queue_payload(30);
      wait_idle();

      // random phases with different idling and lengths
      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
               write_length($urandom);
            end
            1: begin
               sender_idle_pct = 60;
               receiver_stall_pct = 0;
               write_length(32'h0000_0000);
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 60;
               write_length($urandom);
            end
            default: begin
               sender_idle_pct = 10;
               receiver_stall_pct = 10;
               write_length(32'hFFFF_FFFF);
            end
         endcase
         random_phase(100);
         wait_idle();
      end

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
